>>> rtl/mgpd_pkg.sv
// shared constants, types and saturation helper for the mie-gruneisen derivatives core
package mgpd_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] TWO_Q32 = 64'sh0000_0002_0000_0000;
  localparam logic signed [63:0] SMALL_DENOM = 64'sd4294967;

  localparam logic [1:0] REG_SOUND_SPEED = 2'd0;
  localparam logic [1:0] REG_GAMMA = 2'd1;
  localparam logic [1:0] REG_SLOPE = 2'd2;

  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = 66;

  // arrival times of each value, in enabled edges after the input register
  localparam int T_C2 = MUL_LAT;
  localparam int T_K = T_C2 + MUL_LAT;
  localparam int T_J = DIV_LAT;
  localparam int T_A = T_J + 1;
  localparam int T_M1 = T_A + MUL_LAT;
  localparam int T_B = T_M1 + 1;
  localparam int T_MG = T_B + MUL_LAT;
  localparam int T_C = T_MG + 1;
  localparam int T_R = T_C + DIV_LAT;
  localparam int T_E1 = T_R + MUL_LAT;
  localparam int T_E2 = T_E1 + MUL_LAT;
  localparam int T_T3 = T_E2 + MUL_LAT;
  localparam int T_DP1 = T_E1 + DIV_LAT;
  localparam int T_BULK = T_E2 + DIV_LAT;
  localparam int T_DP = T_DP1 + DIV_LAT;
  localparam int T_CSQ = T_DP + DIV_LAT;

  typedef enum logic [1:0] {SAT_NONE, SAT_ZERO, SAT_MAX, SAT_MIN} sat_t;

  function automatic logic signed [63:0] pack(input logic neg, input logic [63:0] m,
                                               input logic over);
    logic signed [63:0] r;
    if (neg) begin
      r = (over || m[63]) ? S64_MIN : signed'(~m + 64'd1);
    end else begin
      r = (over || m[63]) ? S64_MAX : signed'(m);
    end
    return r;
  endfunction

endpackage

>>> rtl/mgpd_if.sv
// item channel interfaces for the mie-gruneisen derivatives core
interface mgpd_in_if;
  logic valid;
  logic ready;
  logic [31:0] reference_density;
  logic [31:0] current_density;
  modport source (output valid, output reference_density, output current_density, input ready);
  modport sink (input valid, input reference_density, input current_density, output ready);
endinterface

interface mgpd_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] pressure;
  logic signed [63:0] pressure_per_density;
  logic signed [63:0] wave_speed_squared;
  logic signed [63:0] bulk_modulus;
  logic ratio_clamped;
  logic denominator_replaced;
  modport source (output valid, output pressure, output pressure_per_density,
                  output wave_speed_squared, output bulk_modulus, output ratio_clamped,
                  output denominator_replaced, input ready);
  modport sink (input valid, input pressure, input pressure_per_density,
                input wave_speed_squared, input bulk_modulus, input ratio_clamped,
                input denominator_replaced, output ready);
endinterface

>>> rtl/mgpd_mul.sv
// pipelined saturating signed multiply with truncating right shift
module mgpd_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         sh,
  output logic signed [63:0] y
);

  logic        neg1, neg2, neg3;
  logic [63:0] ua, ub;
  logic [63:0] p00, p01, p10, p11;
  logic [127:0] prod;
  logic [127:0] shifted;

  assign shifted = prod >> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[63] ^ b[63];
      ua <= a[63] ? (~a + 64'd1) : a;
      ub <= b[63] ? (~b + 64'd1) : b;
      neg2 <= neg1;
      p00 <= ua[31:0] * ub[31:0];
      p01 <= ua[31:0] * ub[63:32];
      p10 <= ua[63:32] * ub[31:0];
      p11 <= ua[63:32] * ub[63:32];
      neg3 <= neg2;
      prod <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
      y <= mgpd_pkg::pack(neg3, shifted[63:0], |shifted[127:64]);
    end
  end

endmodule

>>> rtl/mgpd_div.sv
// pipelined saturating signed divide, one quotient bit per stage
module mgpd_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         sh,
  output logic signed [63:0] q
);

  localparam int Steps = 64;

  logic [63:0] rem [Steps+1];
  logic [63:0] wk [Steps+1];
  logic [63:0] ub [Steps+1];
  logic        neg [Steps+1];
  mgpd_pkg::sat_t kind [Steps+1];

  logic [63:0] nrem [Steps];
  logic [63:0] nwk [Steps];

  logic [63:0]  ua_in, ub_in;
  logic [127:0] num;
  logic         neg_in;
  mgpd_pkg::sat_t kind_in;

  always_comb begin
    ua_in = a[63] ? (~a + 64'd1) : a;
    ub_in = b[63] ? (~b + 64'd1) : b;
    neg_in = a[63] ^ b[63];
    num = {64'd0, ua_in} << sh;
    if (b == 64'sd0) begin
      if (a == 64'sd0) kind_in = mgpd_pkg::SAT_ZERO;
      else kind_in = a[63] ? mgpd_pkg::SAT_MIN : mgpd_pkg::SAT_MAX;
    end else if (num[127:64] >= ub_in) begin
      kind_in = neg_in ? mgpd_pkg::SAT_MIN : mgpd_pkg::SAT_MAX;
    end else begin
      kind_in = mgpd_pkg::SAT_NONE;
    end
  end

  always_comb begin
    logic [64:0] trial;
    logic [64:0] diff;
    for (int k = 0; k < Steps; k++) begin
      trial = {rem[k], wk[k][63]};
      diff = trial - {1'b0, ub[k]};
      if (trial >= {1'b0, ub[k]}) begin
        nrem[k] = diff[63:0];
        nwk[k] = {wk[k][62:0], 1'b1};
      end else begin
        nrem[k] = trial[63:0];
        nwk[k] = {wk[k][62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[127:64];
      wk[0] <= num[63:0];
      ub[0] <= ub_in;
      neg[0] <= neg_in;
      kind[0] <= kind_in;
      for (int k = 1; k <= Steps; k++) begin
        rem[k] <= nrem[k-1];
        wk[k] <= nwk[k-1];
        ub[k] <= ub[k-1];
        neg[k] <= neg[k-1];
        kind[k] <= kind[k-1];
      end
      unique case (kind[Steps])
        mgpd_pkg::SAT_NONE: q <= mgpd_pkg::pack(neg[Steps], wk[Steps], 1'b0);
        mgpd_pkg::SAT_ZERO: q <= 64'sd0;
        mgpd_pkg::SAT_MAX:  q <= mgpd_pkg::S64_MAX;
        mgpd_pkg::SAT_MIN:  q <= mgpd_pkg::S64_MIN;
        default:            q <= 64'sd0;
      endcase
    end
  end

endmodule

>>> rtl/mie_gruneisen_pressure_derivatives_core.sv
// top level of the mie-gruneisen pressure and derivatives core
//
//   channel  | dir | fields
//   in_ch    | in  | reference_density, current_density
//   out_ch   | out | pressure, pressure_per_density, wave_speed_squared, bulk_modulus,
//            |     | ratio_clamped, denominator_replaced
//   cfg      | in  | cfg_write, cfg_index, cfg_data
//
// one item per cycle while no result waits at out_ch
// the path from accept to result valid runs through five chained 64-stage dividers plus the multiplier stages
// reset clears the valid bits and loads the register defaults, no clearing pass
// the whole pipeline holds while a result waits at out_ch; in_ch.ready follows it
module mie_gruneisen_pressure_derivatives_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  mgpd_in_if.sink     in_ch,
  mgpd_out_if.source  out_ch
);

  localparam int ML = mgpd_pkg::MUL_LAT;
  localparam int NRO = ML;
  localparam int NRC = mgpd_pkg::T_DP;
  localparam int NDC = mgpd_pkg::T_DP1 - mgpd_pkg::T_C;
  localparam int NK = mgpd_pkg::T_R - mgpd_pkg::T_K;
  localparam int NC2 = mgpd_pkg::T_R - mgpd_pkg::T_C2;
  localparam int NQ = mgpd_pkg::T_E2 - mgpd_pkg::T_R;
  localparam int NP = mgpd_pkg::T_CSQ - mgpd_pkg::T_E2;
  localparam int NT3 = mgpd_pkg::T_CSQ - mgpd_pkg::T_T3;
  localparam int NBU = mgpd_pkg::T_CSQ - mgpd_pkg::T_BULK;
  localparam int NFL = mgpd_pkg::T_CSQ - mgpd_pkg::T_B;
  localparam int NV = mgpd_pkg::T_CSQ;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [63:0] s;
    s = x + y;
    if (x[63] == y[63] && s[63] != x[63]) s = y[63] ? mgpd_pkg::S64_MIN : mgpd_pkg::S64_MAX;
    return s;
  endfunction

  logic [31:0] sound_speed, gruneisen_gamma, hugoniot_slope;
  logic signed [63:0] c64, g64, s64, gs64;

  logic en;
  logic out_valid;
  logic v0;
  logic [31:0] ro0, rc0;
  logic vl [NV];

  logic signed [63:0] j_q, inv_q, c2_q, k_q, m1_q, mg_q, mgs_q;
  logic signed [63:0] r1_q, r2_q, r3_q, q_q, p1_q, kb_q, t1_q;
  logic signed [63:0] p_q, t2_q, bm_q, dp1_q, t3_q, bulk_q, dp_q, csq_q;

  logic [31:0] ro_dl [NRO];
  logic [31:0] rc_dl [NRC];
  logic signed [63:0] jm1_a, j_a, inv_a;
  logic signed [63:0] jm1a_dl [ML];
  logic signed [63:0] ja_dl [ML];
  logic signed [63:0] inva_dl [ML];
  logic signed [63:0] jm1_b, j_b, d_b;
  logic clamp_b, repl_b;
  logic signed [63:0] jm1b_dl [ML];
  logic signed [63:0] jb_dl [ML];
  logic signed [63:0] db_dl [ML];
  logic signed [63:0] n1_c, n2_c, n3_c, nq_c, d_c;
  logic signed [63:0] dc_dl [NDC];
  logic signed [63:0] k_dl [NK];
  logic signed [63:0] c2_dl [NC2];
  logic signed [63:0] r2_dl [ML];
  logic signed [63:0] q_dl [NQ];
  logic signed [63:0] p_dl [NP];
  logic signed [63:0] t3_dl [NT3];
  logic signed [63:0] bu_dl [NBU];
  logic [1:0] fl_dl [NFL];

  logic signed [63:0] dsum, jm1x, jx, dz, dpdrho;
  logic clampx, replx;

  assign c64 = {32'd0, sound_speed};
  assign g64 = {{32{gruneisen_gamma[31]}}, gruneisen_gamma};
  assign s64 = {32'd0, hugoniot_slope};
  assign gs64 = g64 - s64;

  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_speed <= 32'd327680000;
      gruneisen_gamma <= 32'd33554432;
      hugoniot_slope <= 32'd25165824;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mgpd_pkg::REG_SOUND_SPEED: sound_speed <= cfg_data;
        mgpd_pkg::REG_GAMMA:       gruneisen_gamma <= cfg_data;
        mgpd_pkg::REG_SLOPE:       hugoniot_slope <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NV; i++) vl[i] <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
      vl[0] <= v0;
      for (int i = 1; i < NV; i++) vl[i] <= vl[i-1];
      out_valid <= vl[NV-1];
    end
  end

  // ratio and clamp
  mgpd_div u_j (.clk, .en, .a({32'd0, ro0}), .b({32'd0, rc0}), .sh(6'd32), .q(j_q));
  mgpd_div u_inv (.clk, .en, .a(mgpd_pkg::ONE_Q32), .b(s64), .sh(6'd24), .q(inv_q));
  mgpd_mul u_c2 (.clk, .en, .a(c64), .b(c64), .sh(6'd16), .y(c2_q));
  mgpd_mul u_k (.clk, .en, .a(c2_q), .b({32'd0, ro_dl[NRO-1]}), .sh(6'd16), .y(k_q));
  mgpd_mul u_m1 (.clk, .en, .a(jm1_a), .b(s64), .sh(6'd24), .y(m1_q));

  always_comb begin
    dsum = sat_add(mgpd_pkg::ONE_Q32, m1_q);
    clampx = dsum[63];
    jm1x = clampx ? (64'sd0 - inva_dl[ML-1]) : jm1a_dl[ML-1];
    jx = clampx ? (mgpd_pkg::ONE_Q32 + jm1x) : ja_dl[ML-1];
    dz = clampx ? 64'sd0 : dsum;
    replx = (dz == 64'sd0);
  end

  // numerators and ratios
  mgpd_mul u_mg (.clk, .en, .a(g64), .b(jm1_b), .sh(6'd24), .y(mg_q));
  mgpd_mul u_mgs (.clk, .en, .a(gs64), .b(jm1_b), .sh(6'd24), .y(mgs_q));
  mgpd_div u_r1 (.clk, .en, .a(n1_c), .b(d_c), .sh(6'd32), .q(r1_q));
  mgpd_div u_r2 (.clk, .en, .a(n2_c), .b(d_c), .sh(6'd32), .q(r2_q));
  mgpd_div u_r3 (.clk, .en, .a(n3_c), .b(d_c), .sh(6'd32), .q(r3_q));
  mgpd_div u_q (.clk, .en, .a(nq_c), .b(d_c), .sh(6'd32), .q(q_q));

  // pressure and derivatives
  mgpd_mul u_p1 (.clk, .en, .a(k_dl[NK-1]), .b(r1_q), .sh(6'd32), .y(p1_q));
  mgpd_mul u_kb (.clk, .en, .a(k_dl[NK-1]), .b(r3_q), .sh(6'd32), .y(kb_q));
  mgpd_mul u_t1 (.clk, .en, .a(c2_dl[NC2-1]), .b(r3_q), .sh(6'd32), .y(t1_q));
  mgpd_mul u_p (.clk, .en, .a(p1_q), .b(r2_dl[ML-1]), .sh(6'd33), .y(p_q));
  mgpd_mul u_t2 (.clk, .en, .a(t1_q), .b(q_dl[mgpd_pkg::T_E1-mgpd_pkg::T_R-1]), .sh(6'd32),
                 .y(t2_q));
  mgpd_mul u_bm (.clk, .en, .a(kb_q), .b(q_dl[mgpd_pkg::T_E1-mgpd_pkg::T_R-1]), .sh(6'd32),
                 .y(bm_q));
  mgpd_div u_dp1 (.clk, .en, .a(kb_q), .b(dc_dl[mgpd_pkg::T_E1-mgpd_pkg::T_C-1]), .sh(6'd32),
                  .q(dp1_q));
  mgpd_mul u_t3 (.clk, .en, .a(t2_q), .b(q_dl[NQ-1]), .sh(6'd32), .y(t3_q));
  mgpd_div u_bulk (.clk, .en, .a(bm_q), .b(dc_dl[mgpd_pkg::T_E2-mgpd_pkg::T_C-1]), .sh(6'd32),
                   .q(bulk_q));
  mgpd_div u_dp (.clk, .en, .a(dp1_q), .b(dc_dl[NDC-1]), .sh(6'd32), .q(dp_q));
  mgpd_div u_csq (.clk, .en, .a(dp_q), .b({32'd0, rc_dl[NRC-1]}), .sh(6'd16), .q(csq_q));

  assign dpdrho = (t3_dl[NT3-1] == mgpd_pkg::S64_MIN) ? mgpd_pkg::S64_MAX
                                                      : (64'sd0 - t3_dl[NT3-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      ro0 <= in_ch.reference_density;
      rc0 <= in_ch.current_density;
      ro_dl[0] <= ro0;
      for (int i = 1; i < NRO; i++) ro_dl[i] <= ro_dl[i-1];
      rc_dl[0] <= rc0;
      for (int i = 1; i < NRC; i++) rc_dl[i] <= rc_dl[i-1];

      jm1_a <= j_q - mgpd_pkg::ONE_Q32;
      j_a <= j_q;
      inv_a <= inv_q;
      jm1a_dl[0] <= jm1_a;
      ja_dl[0] <= j_a;
      inva_dl[0] <= inv_a;
      for (int i = 1; i < ML; i++) begin
        jm1a_dl[i] <= jm1a_dl[i-1];
        ja_dl[i] <= ja_dl[i-1];
        inva_dl[i] <= inva_dl[i-1];
      end

      jm1_b <= jm1x;
      j_b <= jx;
      d_b <= replx ? mgpd_pkg::SMALL_DENOM : dz;
      clamp_b <= clampx;
      repl_b <= replx;
      jm1b_dl[0] <= jm1_b;
      jb_dl[0] <= j_b;
      db_dl[0] <= d_b;
      r2_dl[0] <= r2_q;
      for (int i = 1; i < ML; i++) begin
        jm1b_dl[i] <= jm1b_dl[i-1];
        jb_dl[i] <= jb_dl[i-1];
        db_dl[i] <= db_dl[i-1];
        r2_dl[i] <= r2_dl[i-1];
      end

      n1_c <= jm1b_dl[ML-1];
      n2_c <= sat_add(mgpd_pkg::TWO_Q32, mg_q);
      n3_c <= sat_add(mgpd_pkg::ONE_Q32, mgs_q);
      nq_c <= jb_dl[ML-1];
      d_c <= db_dl[ML-1];

      dc_dl[0] <= d_c;
      for (int i = 1; i < NDC; i++) dc_dl[i] <= dc_dl[i-1];
      k_dl[0] <= k_q;
      for (int i = 1; i < NK; i++) k_dl[i] <= k_dl[i-1];
      c2_dl[0] <= c2_q;
      for (int i = 1; i < NC2; i++) c2_dl[i] <= c2_dl[i-1];
      q_dl[0] <= q_q;
      for (int i = 1; i < NQ; i++) q_dl[i] <= q_dl[i-1];
      p_dl[0] <= p_q;
      for (int i = 1; i < NP; i++) p_dl[i] <= p_dl[i-1];
      t3_dl[0] <= t3_q;
      for (int i = 1; i < NT3; i++) t3_dl[i] <= t3_dl[i-1];
      bu_dl[0] <= bulk_q;
      for (int i = 1; i < NBU; i++) bu_dl[i] <= bu_dl[i-1];
      fl_dl[0] <= {clamp_b, repl_b};
      for (int i = 1; i < NFL; i++) fl_dl[i] <= fl_dl[i-1];

      out_ch.pressure <= p_dl[NP-1];
      out_ch.pressure_per_density <= dpdrho;
      out_ch.wave_speed_squared <= csq_q;
      out_ch.bulk_modulus <= bu_dl[NBU-1];
      out_ch.ratio_clamped <= fl_dl[NFL-1][1];
      out_ch.denominator_replaced <= fl_dl[NFL-1][0];
    end
  end

  a_clamp_implies_replace: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.ratio_clamped |-> out_ch.denominator_replaced)
    else $error("clamped item without replaced denominator");

  a_denominator_positive: assert property (@(posedge clk) disable iff (rst)
    vl[mgpd_pkg::T_B-1] |-> !d_b[63] && d_b != 64'sd0)
    else $error("denominator not positive after clamp");

  a_replaced_value: assert property (@(posedge clk) disable iff (rst)
    vl[mgpd_pkg::T_B-1] && repl_b |-> d_b == mgpd_pkg::SMALL_DENOM)
    else $error("replaced denominator has wrong value");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

>>> dv/mgpd_checker.sv
// checker for the mie-gruneisen derivatives core: predicts each result and compares it
module mgpd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  mgpd_in_if          in_ch,
  mgpd_out_if         out_ch,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [63:0] pressure;
    logic signed [63:0] pressure_per_density;
    logic signed [63:0] wave_speed_squared;
    logic signed [63:0] bulk_modulus;
    logic               ratio_clamped;
    logic               denominator_replaced;
  } eos_result_t;

  logic [31:0] sound_speed;
  logic [31:0] gruneisen_gamma;
  logic [31:0] hugoniot_slope;
  eos_result_t owed[$];

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] clip(input bit neg, input logic [63:0] m,
                                              input bit over);
    if (neg) return (over || m[63]) ? mgpd_pkg::S64_MIN : -signed'(m);
    return (over || m[63]) ? mgpd_pkg::S64_MAX : signed'(m);
  endfunction

  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(mgpd_pkg::S64_MAX)) return mgpd_pkg::S64_MAX;
    if (s < 65'(mgpd_pkg::S64_MIN)) return mgpd_pkg::S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
                                                   input logic signed [63:0] b, input int sh);
    logic [127:0] pr;
    pr = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> sh;
    return clip(a[63] != b[63], pr[63:0], pr[127:64] != 0);
  endfunction

  function automatic logic signed [63:0] div_shift(input logic signed [63:0] a,
                                                   input logic signed [63:0] b, input int sh);
    logic [127:0] num;
    logic [127:0] q;
    if (b == 0) return (a == 0) ? 64'sd0 : (a[63] ? mgpd_pkg::S64_MIN : mgpd_pkg::S64_MAX);
    num = {64'd0, mag(a)} << sh;
    if (num[127:64] >= mag(b)) return clip(a[63] != b[63], 64'd0, 1'b1);
    q = num / {64'd0, mag(b)};
    return clip(a[63] != b[63], q[63:0], 1'b0);
  endfunction

  function automatic eos_result_t mie_gruneisen_eval(input logic [31:0] rho0_in,
                                                     input logic [31:0] rho_in);
    eos_result_t r;
    logic signed [63:0] ro, rc, c, g, s, j, jm1, d, r1, r2, r3, q, c2, k, kb, dpdj, dpdrho;
    ro = {32'd0, rho0_in};
    rc = {32'd0, rho_in};
    c = {32'd0, sound_speed};
    g = {{32{gruneisen_gamma[31]}}, gruneisen_gamma};
    s = {32'd0, hugoniot_slope};
    r = '0;
    j = div_shift(ro, rc, 32);
    jm1 = j - mgpd_pkg::ONE_Q32;
    d = sum_sat(mgpd_pkg::ONE_Q32, mul_shift(jm1, s, 24));
    if (d < 0) begin
      r.ratio_clamped = 1'b1;
      jm1 = -div_shift(mgpd_pkg::ONE_Q32, s, 24);
      j = mgpd_pkg::ONE_Q32 + jm1;
      d = 0;
    end
    if (d == 0) begin
      r.denominator_replaced = 1'b1;
      d = mgpd_pkg::SMALL_DENOM;
    end
    r1 = div_shift(jm1, d, 32);
    r2 = div_shift(sum_sat(mgpd_pkg::TWO_Q32, mul_shift(g, jm1, 24)), d, 32);
    r3 = div_shift(sum_sat(mgpd_pkg::ONE_Q32, mul_shift(g - s, jm1, 24)), d, 32);
    q = div_shift(j, d, 32);
    c2 = mul_shift(c, c, 16);
    k = mul_shift(c2, ro, 16);
    r.pressure = mul_shift(mul_shift(k, r1, 32), r2, 33);
    kb = mul_shift(k, r3, 32);
    dpdj = div_shift(div_shift(kb, d, 32), d, 32);
    r.bulk_modulus = div_shift(mul_shift(kb, q, 32), d, 32);
    dpdrho = mul_shift(mul_shift(mul_shift(c2, r3, 32), q, 32), q, 32);
    r.pressure_per_density = (dpdrho == mgpd_pkg::S64_MIN) ? mgpd_pkg::S64_MAX : -dpdrho;
    r.wave_speed_squared = div_shift(dpdj, rc, 16);
    return r;
  endfunction

  assign pending = owed.size();

  always @(posedge clk) begin
    eos_result_t want;
    eos_result_t got;
    if (rst) begin
      sound_speed <= 32'd327680000;
      gruneisen_gamma <= 32'd33554432;
      hugoniot_slope <= 32'd25165824;
      errors <= 0;
      owed.delete();
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          mgpd_pkg::REG_SOUND_SPEED: sound_speed <= cfg_data;
          mgpd_pkg::REG_GAMMA: gruneisen_gamma <= cfg_data;
          mgpd_pkg::REG_SLOPE: hugoniot_slope <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        owed.push_back(mie_gruneisen_eval(in_ch.reference_density, in_ch.current_density));
      if (out_ch.valid && out_ch.ready) begin
        got.pressure = out_ch.pressure;
        got.pressure_per_density = out_ch.pressure_per_density;
        got.wave_speed_squared = out_ch.wave_speed_squared;
        got.bulk_modulus = out_ch.bulk_modulus;
        got.ratio_clamped = out_ch.ratio_clamped;
        got.denominator_replaced = out_ch.denominator_replaced;
        if (owed.size() == 0) begin
          if (errors < 10) $display("unexpected result item: %p", got);
          errors <= errors + 1;
        end else begin
          want = owed.pop_front();
          if (got.pressure !== want.pressure ||
              got.pressure_per_density !== want.pressure_per_density ||
              got.wave_speed_squared !== want.wave_speed_squared ||
              got.bulk_modulus !== want.bulk_modulus ||
              got.ratio_clamped !== want.ratio_clamped ||
              got.denominator_replaced !== want.denominator_replaced) begin
            if (errors < 10) begin
              $display("mismatch: expected p=%0d dpdrho=%0d csq=%0d bulk=%0d clamp=%0b repl=%0b",
                       want.pressure, want.pressure_per_density, want.wave_speed_squared,
                       want.bulk_modulus, want.ratio_clamped, want.denominator_replaced);
              $display("          actual   p=%0d dpdrho=%0d csq=%0d bulk=%0d clamp=%0b repl=%0b",
                       got.pressure, got.pressure_per_density, got.wave_speed_squared,
                       got.bulk_modulus, got.ratio_clamped, got.denominator_replaced);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/mie_gruneisen_pressure_derivatives_core_tb.sv
// testbench top for the mie-gruneisen derivatives core: stimulus, stalls and verdict
module mie_gruneisen_pressure_derivatives_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN = 400;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          idle_cycles;
  int          stall_left;
  bit          calm;

  mgpd_in_if  in_ch ();
  mgpd_out_if out_ch ();

  mie_gruneisen_pressure_derivatives_core u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  mgpd_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("mie_gruneisen_pressure_derivatives_core_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [31:0] rho0, input logic [31:0] rho);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.reference_density <= rho0;
    in_ch.current_density <= rho;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random();
    int mode;
    logic [31:0] base;
    mode = $urandom_range(0, 99);
    base = $urandom_range(32'h0001_0000, 32'h1000_0000);
    if (mode < 50) send_item(base, base + $urandom_range(0, base / 4) - base / 8);
    else if (mode < 80) send_item($urandom, $urandom);
    else if (mode < 90) send_item($urandom_range(0, 3) == 0 ? 32'd0 : $urandom, 32'd0);
    else send_item($urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] c0, input logic [31:0] gam,
                            input logic [31:0] slope);
    cfg_write <= 1'b1;
    cfg_index <= mgpd_pkg::REG_SOUND_SPEED;
    cfg_data <= c0;
    @(posedge clk);
    cfg_index <= mgpd_pkg::REG_GAMMA;
    cfg_data <= gam;
    @(posedge clk);
    cfg_index <= mgpd_pkg::REG_SLOPE;
    cfg_data <= slope;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_extremes();
    send_item(32'd1, 32'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'd1, 32'hFFFF_FFFF);
    send_item(32'd0, 32'd0);
    send_item(32'd5, 32'd0);
    send_item(32'd65536000, 32'd65536000);
    send_item(32'd65536000, 32'd78643200);
    send_item(32'd78643200, 32'd65536000);
    send_item(32'd65536000, 32'h8000_0000);
  endtask

  initial begin
    logic [31:0] phase_cfg[7][3];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = mgpd_pkg::REG_SOUND_SPEED;
    cfg_data = '0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.reference_density = '0;
    in_ch.current_density = '0;
    phase_cfg[0] = '{32'd327680000, 32'd33554432, 32'd25165824};
    phase_cfg[1] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1};
    phase_cfg[2] = '{32'd0, 32'h8000_0000, 32'hFFFF_FFFF};
    phase_cfg[3] = '{$urandom, $urandom, 32'd0};
    phase_cfg[4] = '{32'd65536, 32'd0, 32'h0100_0000};
    phase_cfg[5] = '{$urandom_range(32'h0100_0000, 32'h2000_0000), $urandom,
                     $urandom_range(32'h0080_0000, 32'h0400_0000)};
    phase_cfg[6] = '{$urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        settle();
        write_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
      end
      calm = (ph == 2);
      if (ph == 0 || ph == 1 || ph == 2) send_extremes();
      repeat (65) send_random();
    end
    settle();
    if (errors == 0) begin
      $display("mie_gruneisen_pressure_derivatives_core_tb: done, clean");
    end else begin
      $display("mie_gruneisen_pressure_derivatives_core_tb: done, errors");
    end
    $finish;
  end

endmodule
